>>> sv/sem_pkg.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared sizes, configuration register indexes and the record that travels
// from the window front end to the square-root back end.
// ----------------------------------------------------------------------------
package sem_pkg;

	// Widest image row that the line stores hold.
	localparam int MAX_WIDTH = 1024;
	localparam int COL_W     = $clog2(MAX_WIDTH);
	localparam int ROW_W     = 16;
	localparam int WCFG_W    = 11;
	localparam int PIX_W     = 8;
	localparam int SUM_W     = 16;

	// Depth of the queue between front and back end.
	localparam int QDEPTH    = 4;
	localparam int QPTR_W    = $clog2(QDEPTH);

	// Configuration register indexes.
	typedef enum logic {
		CFG_WIDTH  = 1'b0,
		CFG_HEIGHT = 1'b1
	} cfg_index_t;

	// One queued job: the squared gradient sum and where it belongs.
	typedef struct packed {
		logic [SUM_W-1:0] sum;     // gx^2 + gy^2, or the pixel on a bypass
		logic             clip;    // sum did not fit in SUM_W bits
		logic             bypass;  // single-pixel image, sum holds the pixel
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic             last;
	} sem_entry_t;

	// Queue status seen by both ends.
	typedef struct packed {
		logic full;
		logic empty;
	} sem_qstat_t;

endpackage

>>> sv/sem_front.sv
// ----------------------------------------------------------------------------
// Sobel front end
// Takes pixels, keeps the two line stores and the 3x3 window, forms gx and gy
// and queues the squared gradient sum for every interior pixel.
// ----------------------------------------------------------------------------
module sem_front import sem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [PIX_W-1:0]  s_tdata,
	input  logic [WCFG_W-1:0] width_cfg,
	input  logic [ROW_W-1:0]  height_cfg,
	output logic              push,
	output sem_entry_t        push_entry,
	input  sem_qstat_t        qstat
);

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_CALC = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	fstate_t            state_q;
	logic [PIX_W-1:0]   pix_q;
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [PIX_W-1:0]   win_q [3][2];
	logic [PIX_W-1:0]   upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0]   middle_mem [MAX_WIDTH];
	logic [PIX_W-1:0]   up_rd_q;
	logic [PIX_W-1:0]   mid_rd_q;

	logic signed [10:0] gx_s1;
	logic signed [10:0] gy_s1;
	logic [ROW_W-1:0]   row_s1;
	logic [COL_W-1:0]   col_s1;
	logic               last_s1;
	logic               bypass_s1;

	logic [WCFG_W-1:0]  w_eff;
	logic [ROW_W-1:0]   h_eff;
	logic               end_row;
	logic               end_img;
	logic               one_px;
	logic               interior;
	logic               mem_we;
	logic [11:0]        gx_pos, gx_neg, gy_pos, gy_neg;
	logic [11:0]        gx_w, gy_w;
	logic signed [21:0] gx2, gy2;
	logic [20:0]        sum_w;

	assign s_tready = (state_q == F_IDLE);

	// Effective image size: zero counts as one, width is capped at the store size.
	always_comb begin
		w_eff = width_cfg;
		if (width_cfg == '0)
			w_eff = WCFG_W'(1);
		else if (width_cfg > WCFG_W'(MAX_WIDTH))
			w_eff = WCFG_W'(MAX_WIDTH);
		h_eff = (height_cfg == '0) ? ROW_W'(1) : height_cfg;
	end

	// Position of the current pixel within the image.
	assign end_row  = (({1'b0, col_q} + WCFG_W'(1)) >= w_eff);
	assign end_img  = end_row && (({1'b0, row_q} + (ROW_W+1)'(1)) >= {1'b0, h_eff});
	assign one_px   = (w_eff == WCFG_W'(1)) && (h_eff == ROW_W'(1));
	assign interior = (row_q >= ROW_W'(2)) && (col_q >= COL_W'(2));
	assign mem_we   = (state_q == F_CALC) && !one_px;

	// Sobel sums; the window's newest column comes from the stores and the pixel.
	always_comb begin
		gx_pos = 12'(up_rd_q) + {3'b0, mid_rd_q, 1'b0} + 12'(pix_q);
		gx_neg = 12'(win_q[0][0]) + {3'b0, win_q[1][0], 1'b0} + 12'(win_q[2][0]);
		gy_pos = 12'(win_q[0][0]) + {3'b0, win_q[0][1], 1'b0} + 12'(up_rd_q);
		gy_neg = 12'(win_q[2][0]) + {3'b0, win_q[2][1], 1'b0} + 12'(pix_q);
		gx_w   = gx_pos - gx_neg;
		gy_w   = gy_pos - gy_neg;
	end

	// Squares of the registered gradients.
	assign gx2   = gx_s1 * gx_s1;
	assign gy2   = gy_s1 * gy_s1;
	assign sum_w = {1'b0, gx2[19:0]} + {1'b0, gy2[19:0]};

	// Queue record, either a gradient job or a passed-through pixel.
	always_comb begin
		push_entry.sum    = bypass_s1 ? SUM_W'(pix_q) : sum_w[SUM_W-1:0];
		push_entry.clip   = !bypass_s1 && (sum_w[20:SUM_W] != '0);
		push_entry.bypass = bypass_s1;
		push_entry.row    = row_s1;
		push_entry.col    = col_s1;
		push_entry.last   = last_s1;
	end

	assign push = (state_q == F_PUSH) && !qstat.full;

	// Line stores: the read is registered, the write goes to the same column.
	always_ff @(posedge clk) begin
		up_rd_q  <= upper_mem[col_q];
		mid_rd_q <= middle_mem[col_q];
		if (mem_we) begin
			upper_mem[col_q]  <= mid_rd_q;
			middle_mem[col_q] <= pix_q;
		end
	end

	// Per-pixel registers for the push step.
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			pix_q <= s_tdata;
		if (state_q == F_CALC) begin
			gx_s1     <= gx_w[10:0];
			gy_s1     <= gy_w[10:0];
			row_s1    <= one_px ? '0 : row_q - ROW_W'(1);
			col_s1    <= one_px ? '0 : col_q - COL_W'(1);
			last_s1   <= one_px || end_img;
			bypass_s1 <= one_px;
		end
	end

	// Sequencer, window shift and position counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			row_q   <= '0;
			col_q   <= '0;
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= '0;
				win_q[r][1] <= '0;
			end
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (s_tvalid)
						state_q <= F_CALC;
				end
				F_CALC: begin
					if (one_px) begin
						row_q   <= '0;
						col_q   <= '0;
						state_q <= F_PUSH;
					end else begin
						win_q[0][0] <= win_q[0][1];
						win_q[1][0] <= win_q[1][1];
						win_q[2][0] <= win_q[2][1];
						win_q[0][1] <= up_rd_q;
						win_q[1][1] <= mid_rd_q;
						win_q[2][1] <= pix_q;
						if (end_img) begin
							row_q <= '0;
							col_q <= '0;
						end else if (end_row) begin
							row_q <= row_q + ROW_W'(1);
							col_q <= '0;
						end else begin
							col_q <= col_q + COL_W'(1);
						end
						state_q <= interior ? F_PUSH : F_IDLE;
					end
				end
				F_PUSH: begin
					if (!qstat.full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

>>> sv/sem_queue.sv
// ----------------------------------------------------------------------------
// Sobel job queue
// Short first-in first-out store that lets front and back end stall apart.
// ----------------------------------------------------------------------------
module sem_queue import sem_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sem_entry_t push_entry,
	input  logic       pop,
	output sem_entry_t pop_entry,
	output sem_qstat_t qstat
);

	sem_entry_t        slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;

	assign qstat.full  = (cnt_q == (QPTR_W+1)'(QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign pop_entry   = slot_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (push && !pop)
				cnt_q <= cnt_q + (QPTR_W+1)'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - (QPTR_W+1)'(1);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && qstat.full))
		else $error("queue written while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && qstat.empty))
		else $error("queue read while empty");
`endif

endmodule

>>> sv/sem_back.sv
// ----------------------------------------------------------------------------
// Sobel back end
// Takes a queued sum, finds its integer square root bit by bit and
// holds the result in the output register until it is transferred.
// ----------------------------------------------------------------------------
module sem_back import sem_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	output logic             pop,
	input  sem_entry_t       pop_entry,
	input  sem_qstat_t       qstat,
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,
	output logic [0:0]       m_tuser,
	output logic             m_tlast
);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RUN  = 3'b010,
		B_DONE = 3'b100
	} bstate_t;

	bstate_t          state_q;
	sem_entry_t       job_q;
	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;
	logic [2:0]       step_q;
	logic [PIX_W-1:0] mag_q;

	logic             out_valid_q;
	logic [PIX_W-1:0] out_mag_q;
	logic [ROW_W-1:0] out_row_q;
	logic [COL_W-1:0] out_col_q;
	logic             out_clip_q;
	logic             out_last_q;

	logic [SUM_W-1:0] bit_w;
	logic [SUM_W-1:0] trial_w;
	logic             take_w;
	logic [SUM_W-1:0] root_nxt;
	logic             out_free;

	assign pop      = (state_q == B_IDLE) && !qstat.empty;
	assign out_free = !out_valid_q || m_tready;

	// One square-root step: the trial bit walks down from bit 14, two at a time.
	always_comb begin
		bit_w    = SUM_W'(1) << {3'd7 - step_q, 1'b0};
		trial_w  = root_q + bit_w;
		take_w   = (rem_q >= trial_w);
		root_nxt = take_w ? ((root_q >> 1) + bit_w) : (root_q >> 1);
	end

	// Root sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						step_q  <= '0;
						state_q <= (pop_entry.clip || pop_entry.bypass) ? B_DONE : B_RUN;
					end
				end
				B_RUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7)
						state_q <= B_DONE;
				end
				B_DONE: begin
					if (out_free)
						state_q <= B_IDLE;
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	// Root datapath and job record.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q  <= pop_entry;
			rem_q  <= pop_entry.sum;
			root_q <= '0;
			mag_q  <= pop_entry.clip ? '1 : pop_entry.sum[PIX_W-1:0];
		end else if (state_q == B_RUN) begin
			if (take_w)
				rem_q <= rem_q - trial_w;
			root_q <= root_nxt;
			if (step_q == 3'd7)
				mag_q <= root_nxt[PIX_W-1:0];
		end
	end

	// Output register, loaded when empty or when its result is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == B_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_DONE && out_free) begin
			out_mag_q  <= mag_q;
			out_row_q  <= job_q.row;
			out_col_q  <= job_q.col;
			out_clip_q <= job_q.clip;
			out_last_q <= job_q.last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'b0, out_col_q, out_row_q, out_mag_q};
	assign m_tuser  = out_clip_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_clip_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_clip_q |-> out_mag_q == '1)
		else $error("clipped result not saturated");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> state_q != B_IDLE)
		else $error("job taken but root sequencer stayed idle");
`endif

endmodule

>>> sv/sobel_edge_magnitude_3x3.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude, 3x3
// Streaming gradient magnitude of a grey image in raster order.
// ----------------------------------------------------------------------------
// Pixels are taken one at a time; the front end takes no new pixel before it
// is done with the last: a border pixel passes only the calculate state, one
// that gives a result also the push state, which waits while the queue is
// full. Each result then goes through a queue of four jobs into the
// square-root unit, which takes no new job until its last result is in the
// output register; a saturated result or a single-pixel image skips the root
// steps. Results carry the magnitude, the center's row and column, a clip flag
// on tuser and tlast on the final interior result of the image. The user must
// write the width and height registers only while no pixel is in flight; the
// block itself does not enforce it.
module sobel_edge_magnitude_3x3 import sem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] pixel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] magnitude, [23:8] center_row, [33:24] center_col
	output logic [0:0]  m_tuser,   // [0] clipped
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	logic [WCFG_W-1:0] width_q;
	logic [ROW_W-1:0]  height_q;
	logic              push;
	sem_entry_t        push_entry;
	logic              pop;
	sem_entry_t        pop_entry;
	sem_qstat_t        qstat;
	cfg_index_t        cfg_sel;

	assign cfg_ready = 1'b1;
	assign cfg_sel   = cfg_index_t'(cfg_index);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WCFG_W'(1024);
			height_q <= ROW_W'(1024);
		end else if (cfg_valid) begin
			unique case (cfg_sel)
				CFG_WIDTH:  width_q  <= cfg_data[WCFG_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[ROW_W-1:0];
				default: ;
			endcase
		end
	end

	sem_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.width_cfg  (width_q),
		.height_cfg (height_q),
		.push       (push),
		.push_entry (push_entry),
		.qstat      (qstat)
	);

	sem_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.qstat      (qstat)
	);

	sem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop       (pop),
		.pop_entry (pop_entry),
		.qstat     (qstat),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule
